>>> sv/ipu_pkg.sv
package ipu_pkg;

    // fixed-point formats
    localparam int FRAC      = 28;
    localparam int PIX_W     = 16;
    localparam int COORD_W   = 32;
    localparam int WIDE_W    = 48;
    localparam int SUM_W     = 52;
    localparam int DIV_STEPS = PIX_W + FRAC;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [WIDE_W-1:0]  wide_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    // one point between iteration stages
    typedef struct packed {
        coord_t x0;
        coord_t y0;
        coord_t xc;
        coord_t yc;
    } iter_ctx_t;

    // saturation bounds, held at sum width
    localparam sum_t WIDE_HI  = sum_t'({1'b0, {(WIDE_W-1){1'b1}}});
    localparam sum_t WIDE_LO  = -WIDE_HI - 1;
    localparam sum_t COORD_HI = sum_t'({1'b0, {(COORD_W-1){1'b1}}});
    localparam sum_t COORD_LO = -COORD_HI - 1;

    function automatic wide_t to_wide(input coord_t c);
        return WIDE_W'(c);
    endfunction

    function automatic sum_t to_sum(input wide_t w);
        return SUM_W'(w);
    endfunction

    // clamp a sum to the wide Q20.28 range
    function automatic wide_t wsat(input sum_t v);
        wide_t r;
        if (v > WIDE_HI)
            r = wide_t'(WIDE_HI);
        else if (v < WIDE_LO)
            r = wide_t'(WIDE_LO);
        else
            r = wide_t'(v);
        return r;
    endfunction

    // clamp a sum to the Q4.28 coordinate range
    function automatic coord_t csat(input sum_t v);
        coord_t r;
        if (v > COORD_HI)
            r = coord_t'(COORD_HI);
        else if (v < COORD_LO)
            r = coord_t'(COORD_LO);
        else
            r = coord_t'(v);
        return r;
    endfunction

endpackage

>>> sv/iterative_point_undistortion_core.sv
// Inverts the radial-tangential lens model for one pixel pair per cycle:
// a new point may be started in every cycle (busy never rises) and each
// result appears for one cycle under done. The pipeline is the pixel divider
// (one quotient bit per stage), 13 stages per iteration set by its chain of
// five multipliers, and the pixel mapping registers. Results cannot be held
// off, so the receiver must take every done beat. Configuration registers
// are read live by every stage and may only change while no point is in
// flight.
module iterative_point_undistortion_core
    import ipu_pkg::*;
#(
    parameter int                 ITERATIONS = 10,
    parameter logic signed [31:0] RADIAL_K3  = 32'sd0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [PIX_W-1:0]   dist_u,
    input  logic [PIX_W-1:0]   dist_v,
    output logic               done,
    output logic signed [19:0] undist_u,
    output logic signed [19:0] undist_v,
    output logic               clipped,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [31:0]        cfg_wdata
);

    localparam int OUT_W  = 20;
    localparam int PROD_W = PIX_W + 1 + COORD_W;
    localparam int PSUM_W = PROD_W + 1;

    localparam logic [2:0] CFG_FOCAL_X  = 3'd0;
    localparam logic [2:0] CFG_FOCAL_Y  = 3'd1;
    localparam logic [2:0] CFG_CENTER_X = 3'd2;
    localparam logic [2:0] CFG_CENTER_Y = 3'd3;
    localparam logic [2:0] CFG_K1       = 3'd4;
    localparam logic [2:0] CFG_K2       = 3'd5;
    localparam logic [2:0] CFG_P1       = 3'd6;
    localparam logic [2:0] CFG_P2       = 3'd7;

    localparam logic signed [PSUM_W-1:0] ROUND  = PSUM_W'(1) <<< (FRAC - 1);
    localparam logic signed [PSUM_W-1:0] OUT_HI = PSUM_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [PSUM_W-1:0] OUT_LO = -OUT_HI - 1;

    logic [PIX_W-1:0] focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;
    coord_t           k1_reg, k2_reg, p1_reg, p2_reg;
    logic [PIX_W-1:0] fdx, fdy;
    logic signed [PIX_W:0] diff_u, diff_v;

    logic   x_vld, y_vld;
    coord_t x0_w, y0_w;

    iter_ctx_t ctx_w [0:ITERATIONS];
    logic      vld_w [0:ITERATIONS];

    logic signed [PROD_W-1:0] pu_next, pv_next, pu_reg, pv_reg;
    logic                     pix_vld_reg;
    logic signed [PSUM_W-1:0] su, sv;
    logic                     clip_u, clip_v;
    logic signed [OUT_W-1:0]  u_next, v_next, u_reg, v_reg;
    logic                     clipped_reg, done_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= PIX_W'(8000);
            focal_y_reg  <= PIX_W'(8000);
            center_x_reg <= PIX_W'(5120);
            center_y_reg <= PIX_W'(3840);
            k1_reg       <= '0;
            k2_reg       <= '0;
            p1_reg       <= '0;
            p2_reg       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_FOCAL_X:  focal_x_reg  <= cfg_wdata[PIX_W-1:0];
                CFG_FOCAL_Y:  focal_y_reg  <= cfg_wdata[PIX_W-1:0];
                CFG_CENTER_X: center_x_reg <= cfg_wdata[PIX_W-1:0];
                CFG_CENTER_Y: center_y_reg <= cfg_wdata[PIX_W-1:0];
                CFG_K1:       k1_reg       <= coord_t'(cfg_wdata);
                CFG_K2:       k2_reg       <= coord_t'(cfg_wdata);
                CFG_P1:       p1_reg       <= coord_t'(cfg_wdata);
                CFG_P2:       p2_reg       <= coord_t'(cfg_wdata);
                default:      ;
            endcase
        end
    end

    // zero focal length acts as one
    assign fdx = (focal_x_reg == '0) ? PIX_W'(1) : focal_x_reg;
    assign fdy = (focal_y_reg == '0) ? PIX_W'(1) : focal_y_reg;

    // offsets from the principal point
    assign diff_u = $signed({1'b0, dist_u}) - $signed({1'b0, center_x_reg});
    assign diff_v = $signed({1'b0, dist_v}) - $signed({1'b0, center_y_reg});

    assign busy = 1'b0;

    // normalization dividers
    ipu_div u_div_x (
        .clk(clk), .rst_n(rst_n), .in_valid(start), .diff(diff_u), .divisor(fdx),
        .out_valid(x_vld), .coord(x0_w)
    );

    ipu_div u_div_y (
        .clk(clk), .rst_n(rst_n), .in_valid(start), .diff(diff_v), .divisor(fdy),
        .out_valid(y_vld), .coord(y0_w)
    );

    // first estimate is the distorted point itself
    assign vld_w[0]    = x_vld & y_vld;
    assign ctx_w[0].x0 = x0_w;
    assign ctx_w[0].y0 = y0_w;
    assign ctx_w[0].xc = x0_w;
    assign ctx_w[0].yc = y0_w;

    // one pipeline section per iteration
    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_iter
        ipu_iter #(.RADIAL_K3(RADIAL_K3)) u_iter (
            .clk(clk), .rst_n(rst_n),
            .in_valid(vld_w[i]), .in_ctx(ctx_w[i]),
            .k1(k1_reg), .k2(k2_reg), .p1(p1_reg), .p2(p2_reg),
            .out_valid(vld_w[i+1]), .out_ctx(ctx_w[i+1])
        );
    end

    // back to pixels: scale by focal length
    assign pu_next = $signed({1'b0, fdx}) * ctx_w[ITERATIONS].xc;
    assign pv_next = $signed({1'b0, fdy}) * ctx_w[ITERATIONS].yc;

    // round half up, add principal point, saturate
    always_comb
    begin
        su = ((PSUM_W'(pu_reg) + ROUND) >>> FRAC) + PSUM_W'($signed({1'b0, center_x_reg}));
        sv = ((PSUM_W'(pv_reg) + ROUND) >>> FRAC) + PSUM_W'($signed({1'b0, center_y_reg}));
        clip_u = (su > OUT_HI) || (su < OUT_LO);
        clip_v = (sv > OUT_HI) || (sv < OUT_LO);
        if (su > OUT_HI)
            u_next = OUT_W'(OUT_HI);
        else if (su < OUT_LO)
            u_next = OUT_W'(OUT_LO);
        else
            u_next = OUT_W'(su);
        if (sv > OUT_HI)
            v_next = OUT_W'(OUT_HI);
        else if (sv < OUT_LO)
            v_next = OUT_W'(OUT_LO);
        else
            v_next = OUT_W'(sv);
    end

    always_ff @(posedge clk)
    begin
        pu_reg      <= pu_next;
        pv_reg      <= pv_next;
        u_reg       <= u_next;
        v_reg       <= v_next;
        clipped_reg <= clip_u | clip_v;
    end

    // result beat strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            pix_vld_reg <= vld_w[ITERATIONS];
            done_reg    <= pix_vld_reg;
        end
    end

    assign done     = done_reg;
    assign undist_u = u_reg;
    assign undist_v = v_reg;
    assign clipped  = clipped_reg;

endmodule

>>> sv/ipu_qmul.sv
module ipu_qmul
    import ipu_pkg::*;
(
    input  logic  clk,
    input  wide_t a,
    input  wide_t b,
    output wide_t p
);

    localparam int HALF_W = WIDE_W / 2;
    localparam int BIG_LIM_W = WIDE_W - 1 - (WIDE_W - FRAC);

    logic [WIDE_W-1:0] ma, mb;
    logic [HALF_W-1:0] ah, al, bh, bl;
    logic [WIDE_W-1:0] ll_next, lh_next, hl_next, hh_next;
    logic [WIDE_W-1:0] ll_reg, lh_reg, hl_reg, hh_reg;
    logic              neg_next, neg_reg;
    logic [WIDE_W:0]   mid, t, big;
    logic [WIDE_W-1:0] res;
    wide_t             p_next, p_reg;

    localparam logic [WIDE_W-1:0] RES_LIM = WIDE_W'(1) << (WIDE_W - 1);
    localparam logic [WIDE_W-1:0] POS_LIM = RES_LIM - 1;

    // magnitudes and four half-width partial products
    always_comb
    begin
        ma = a[WIDE_W-1] ? WIDE_W'(-a) : a;
        mb = b[WIDE_W-1] ? WIDE_W'(-b) : b;
        ah = ma[WIDE_W-1:HALF_W];
        al = ma[HALF_W-1:0];
        bh = mb[WIDE_W-1:HALF_W];
        bl = mb[HALF_W-1:0];
        ll_next  = al * bl;
        lh_next  = al * bh;
        hl_next  = ah * bl;
        hh_next  = ah * bh;
        neg_next = a[WIDE_W-1] ^ b[WIDE_W-1];
    end

    // recombine, drop fraction bits, saturate, apply sign
    always_comb
    begin
        mid = {1'b0, lh_reg} + {1'b0, hl_reg};
        t   = {1'b0, ll_reg} + {1'b0, mid[HALF_W-1:0], {HALF_W{1'b0}}};
        big = {1'b0, hh_reg} + {{(WIDE_W-HALF_W){1'b0}}, mid[WIDE_W:HALF_W]};
        if (big >= ((WIDE_W+1)'(1) << BIG_LIM_W))
            res = RES_LIM;
        else
        begin
            res = WIDE_W'({big[BIG_LIM_W-1:0], {(WIDE_W-FRAC){1'b0}}})
                + WIDE_W'(t[WIDE_W:FRAC]);
            if (res > RES_LIM)
                res = RES_LIM;
        end
        if (neg_reg)
            p_next = wide_t'(-res);
        else if (res > POS_LIM)
            p_next = wide_t'(POS_LIM);
        else
            p_next = wide_t'(res);
    end

    always_ff @(posedge clk)
    begin
        ll_reg  <= ll_next;
        lh_reg  <= lh_next;
        hl_reg  <= hl_next;
        hh_reg  <= hh_next;
        neg_reg <= neg_next;
        p_reg   <= p_next;
    end

    assign p = p_reg;

endmodule

>>> sv/ipu_div.sv
module ipu_div
    import ipu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [PIX_W:0] diff,
    input  logic [PIX_W-1:0]   divisor,
    output logic               out_valid,
    output coord_t             coord
);

    localparam logic [DIV_STEPS-1:0] POS_LIM = DIV_STEPS'({1'b0, {(COORD_W-1){1'b1}}});
    localparam logic [DIV_STEPS-1:0] NEG_LIM = POS_LIM + 1;

    logic                 vld_next [0:DIV_STEPS];
    logic                 vld_reg  [0:DIV_STEPS];
    logic [PIX_W-1:0]     mag_next [0:DIV_STEPS];
    logic [PIX_W-1:0]     mag_reg  [0:DIV_STEPS];
    logic [PIX_W-1:0]     rem_next [0:DIV_STEPS];
    logic [PIX_W-1:0]     rem_reg  [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] quo_next [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] quo_reg  [0:DIV_STEPS];
    logic                 neg_next [0:DIV_STEPS];
    logic                 neg_reg  [0:DIV_STEPS];
    logic [PIX_W:0]       trial;
    logic                 fits;
    logic [DIV_STEPS-1:0] q;
    coord_t               coord_next, coord_reg;
    logic                 out_vld_reg;

    // entry stage and one restoring quotient bit per stage
    always_comb
    begin
        trial        = '0;
        fits         = 1'b0;
        vld_next[0]  = in_valid;
        neg_next[0]  = diff < 0;
        mag_next[0]  = (diff < 0) ? PIX_W'(-diff) : diff[PIX_W-1:0];
        rem_next[0]  = '0;
        quo_next[0]  = '0;
        for (int k = 1; k <= DIV_STEPS; k++)
        begin
            trial       = {rem_reg[k-1], mag_reg[k-1][PIX_W-1]};
            fits        = trial >= {1'b0, divisor};
            rem_next[k] = fits ? PIX_W'(trial - {1'b0, divisor}) : trial[PIX_W-1:0];
            quo_next[k] = {quo_reg[k-1][DIV_STEPS-2:0], fits};
            mag_next[k] = mag_reg[k-1] << 1;
            neg_next[k] = neg_reg[k-1];
            vld_next[k] = vld_reg[k-1];
        end
    end

    // saturate quotient to the coordinate range
    always_comb
    begin
        q = quo_reg[DIV_STEPS];
        if (neg_reg[DIV_STEPS])
            coord_next = (q >= NEG_LIM) ? coord_t'(COORD_LO)
                                        : coord_t'(0) - coord_t'(q[COORD_W-1:0]);
        else
            coord_next = (q > POS_LIM) ? coord_t'(COORD_HI) : coord_t'(q[COORD_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= DIV_STEPS; k++)
        begin
            mag_reg[k] <= mag_next[k];
            rem_reg[k] <= rem_next[k];
            quo_reg[k] <= quo_next[k];
            neg_reg[k] <= neg_next[k];
        end
        coord_reg <= coord_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_STEPS; k++)
                vld_reg[k] <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            for (int k = 0; k <= DIV_STEPS; k++)
                vld_reg[k] <= vld_next[k];
            out_vld_reg <= vld_reg[DIV_STEPS];
        end
    end

    assign out_valid = out_vld_reg;
    assign coord     = coord_reg;

endmodule

>>> sv/ipu_iter.sv
module ipu_iter
    import ipu_pkg::*;
#(
    parameter logic signed [31:0] RADIAL_K3 = 32'sd0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  iter_ctx_t in_ctx,
    input  coord_t    k1,
    input  coord_t    k2,
    input  coord_t    p1,
    input  coord_t    p2,
    output logic      out_valid,
    output iter_ctx_t out_ctx
);

    localparam int CTX_DEPTH = 12;
    localparam int DX_DEPTH  = 7;
    localparam int KR1_DEPTH = 4;
    localparam int KR2_DEPTH = 2;
    localparam int R2_DEPTH  = 2;

    wide_t xx_w, yy_w, xy_w;
    wide_t r4_w, kr1_w, tx1_w, tx2_w, ty1_w, ty2_w;
    wide_t r6_w, kr2_w, kr3_w, px_w, py_w;
    wide_t r2_next, a1_next, a2_next, a3_next;
    wide_t r2_reg, a1_reg, a2_reg, a3_reg;
    wide_t dx_next, dy_next, cd_next, cd_reg;
    wide_t r2d_reg [0:R2_DEPTH-1];
    wide_t kr1d_reg [0:KR1_DEPTH-1];
    wide_t kr2d_reg [0:KR2_DEPTH-1];
    wide_t dx_reg [0:DX_DEPTH-1];
    wide_t dy_reg [0:DX_DEPTH-1];
    iter_ctx_t ctx_reg [0:CTX_DEPTH-1];
    iter_ctx_t out_next, out_reg;
    logic      vld_reg [0:CTX_DEPTH];
    sum_t      nx_sum, ny_sum;

    // squares and cross term of the current estimate
    ipu_qmul u_xx (.clk(clk), .a(to_wide(in_ctx.xc)), .b(to_wide(in_ctx.xc)), .p(xx_w));
    ipu_qmul u_yy (.clk(clk), .a(to_wide(in_ctx.yc)), .b(to_wide(in_ctx.yc)), .p(yy_w));
    ipu_qmul u_xy (.clk(clk), .a(to_wide(in_ctx.xc)), .b(to_wide(in_ctx.yc)), .p(xy_w));

    // r4, k1 term and tangential products
    ipu_qmul u_r4  (.clk(clk), .a(r2_reg),      .b(r2_reg), .p(r4_w));
    ipu_qmul u_kr1 (.clk(clk), .a(to_wide(k1)), .b(r2_reg), .p(kr1_w));
    ipu_qmul u_tx1 (.clk(clk), .a(to_wide(p1)), .b(a1_reg), .p(tx1_w));
    ipu_qmul u_tx2 (.clk(clk), .a(to_wide(p2)), .b(a2_reg), .p(tx2_w));
    ipu_qmul u_ty1 (.clk(clk), .a(to_wide(p1)), .b(a3_reg), .p(ty1_w));
    ipu_qmul u_ty2 (.clk(clk), .a(to_wide(p2)), .b(a1_reg), .p(ty2_w));

    // r6 and k2 term
    ipu_qmul u_r6  (.clk(clk), .a(r4_w),        .b(r2d_reg[R2_DEPTH-1]), .p(r6_w));
    ipu_qmul u_kr2 (.clk(clk), .a(to_wide(k2)), .b(r4_w),                .p(kr2_w));

    // k3 term
    ipu_qmul u_kr3 (.clk(clk), .a(to_wide(RADIAL_K3)), .b(r6_w), .p(kr3_w));

    // radial correction applied to the estimate
    ipu_qmul u_px (.clk(clk), .a(to_wide(ctx_reg[CTX_DEPTH-3].xc)), .b(cd_reg), .p(px_w));
    ipu_qmul u_py (.clk(clk), .a(to_wide(ctx_reg[CTX_DEPTH-3].yc)), .b(cd_reg), .p(py_w));

    // saturating sums between the multiplier stages
    always_comb
    begin
        r2_next = wsat(to_sum(xx_w) + to_sum(yy_w));
        a1_next = wsat(to_sum(xy_w) <<< 1);
        a2_next = wsat(to_sum(r2_next) + (to_sum(xx_w) <<< 1));
        a3_next = wsat(to_sum(r2_next) + (to_sum(yy_w) <<< 1));
        dx_next = wsat(to_sum(tx1_w) + to_sum(tx2_w));
        dy_next = wsat(to_sum(ty1_w) + to_sum(ty2_w));
        cd_next = wsat(to_sum(kr1d_reg[KR1_DEPTH-1]) + to_sum(kr2d_reg[KR2_DEPTH-1])
                       + to_sum(kr3_w));
        nx_sum  = to_sum(to_wide(ctx_reg[CTX_DEPTH-1].x0)) - to_sum(px_w)
                  - to_sum(dx_reg[DX_DEPTH-1]);
        ny_sum  = to_sum(to_wide(ctx_reg[CTX_DEPTH-1].y0)) - to_sum(py_w)
                  - to_sum(dy_reg[DX_DEPTH-1]);
        out_next.x0 = ctx_reg[CTX_DEPTH-1].x0;
        out_next.y0 = ctx_reg[CTX_DEPTH-1].y0;
        out_next.xc = csat(nx_sum);
        out_next.yc = csat(ny_sum);
    end

    // data stages and delay lines
    always_ff @(posedge clk)
    begin
        r2_reg <= r2_next;
        a1_reg <= a1_next;
        a2_reg <= a2_next;
        a3_reg <= a3_next;
        cd_reg <= cd_next;
        out_reg <= out_next;
        ctx_reg[0]  <= in_ctx;
        r2d_reg[0]  <= r2_reg;
        kr1d_reg[0] <= kr1_w;
        kr2d_reg[0] <= kr2_w;
        dx_reg[0]   <= dx_next;
        dy_reg[0]   <= dy_next;
        for (int k = 1; k < CTX_DEPTH; k++)
            ctx_reg[k] <= ctx_reg[k-1];
        for (int k = 1; k < R2_DEPTH; k++)
            r2d_reg[k] <= r2d_reg[k-1];
        for (int k = 1; k < KR1_DEPTH; k++)
            kr1d_reg[k] <= kr1d_reg[k-1];
        for (int k = 1; k < KR2_DEPTH; k++)
            kr2d_reg[k] <= kr2d_reg[k-1];
        for (int k = 1; k < DX_DEPTH; k++)
        begin
            dx_reg[k] <= dx_reg[k-1];
            dy_reg[k] <= dy_reg[k-1];
        end
    end

    // valid bits follow the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= CTX_DEPTH; k++)
                vld_reg[k] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= CTX_DEPTH; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    assign out_valid = vld_reg[CTX_DEPTH];
    assign out_ctx   = out_reg;

endmodule

>>> bench/tb_iterative_point_undistortion_core.sv
module tb_iterative_point_undistortion_core
    import ipu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROUNDS    = 10;
    localparam int LATENCY   = 48 + 13 * ROUNDS;

    // register indexes
    localparam logic [2:0] REG_FOCAL_X  = 3'd0;
    localparam logic [2:0] REG_FOCAL_Y  = 3'd1;
    localparam logic [2:0] REG_CENTER_X = 3'd2;
    localparam logic [2:0] REG_CENTER_Y = 3'd3;
    localparam logic [2:0] REG_K1       = 3'd4;
    localparam logic [2:0] REG_K2       = 3'd5;
    localparam logic [2:0] REG_P1       = 3'd6;
    localparam logic [2:0] REG_P2       = 3'd7;

    localparam longint W_HI = 64'sh7FFFFFFFFFFF;
    localparam longint W_LO = -W_HI - 1;
    localparam longint C_HI = 64'sd2147483647;
    localparam longint C_LO = -64'sd2147483648;

    typedef struct {
        logic signed [19:0] u;
        logic signed [19:0] v;
        logic               clip;
    } pixel_out_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [PIX_W-1:0]   dist_u;
    logic [PIX_W-1:0]   dist_v;
    logic               done;
    logic signed [19:0] undist_u;
    logic signed [19:0] undist_v;
    logic               clipped;
    logic               cfg_we;
    logic [2:0]         cfg_addr;
    logic [31:0]        cfg_wdata;

    // shadow copy of the lens registers
    longint unsigned lens_fx, lens_fy, lens_cx, lens_cy;
    longint          lens_k1, lens_k2, lens_p1, lens_p2;

    pixel_out_t pending_pixels[$];
    int         mismatches;
    bit         tail_quiet;

    iterative_point_undistortion_core #(.ITERATIONS(ROUNDS)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .dist_u(dist_u), .dist_v(dist_v), .done(done),
        .undist_u(undist_u), .undist_v(undist_v), .clipped(clipped),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint clamp64(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // fixed-point product a*b/2^28, truncated toward zero, wide saturated
    function automatic longint fx_mul(longint a, longint b);
        bit neg;
        logic [127:0] ma, mb, pr;
        logic [127:0] res;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? 128'(-a) : 128'(a);
        mb = (b < 0) ? 128'(-b) : 128'(b);
        ma &= 128'hFFFFFFFFFFFF;
        mb &= 128'hFFFFFFFFFFFF;
        pr = ma * mb;
        res = pr >> 28;
        if (res > (128'd1 << 47))
            res = 128'd1 << 47;
        if (neg)
            return -longint'(res[63:0]);
        if (res > 128'(W_HI))
            res = 128'(W_HI);
        return longint'(res[63:0]);
    endfunction

    function automatic longint wclamp(longint v);
        return clamp64(v, W_LO, W_HI);
    endfunction

    function automatic longint norm_coord(longint unsigned p, longint unsigned c,
                                          longint unsigned f);
        longint diff;
        longint unsigned fd, mag;
        diff = longint'(p) - longint'(c);
        fd = (f == 0) ? 1 : f;
        mag = (diff < 0) ? longint'(-diff) : diff;
        mag = (mag << 28) / fd;
        if (mag > (64'd1 << 32))
            mag = 64'd1 << 32;
        return clamp64((diff < 0) ? -longint'(mag) : longint'(mag), C_LO, C_HI);
    endfunction

    function automatic longint map_pixel(longint xn, longint unsigned c,
                                         longint unsigned f, ref bit clip);
        longint unsigned fd;
        longint p, r, v;
        fd = (f == 0) ? 1 : f;
        p = longint'(fd) * xn + (64'sd1 <<< 27);
        r = p >>> 28;
        v = r + longint'(c);
        if (v > 524287 || v < -524288)
        begin
            clip = 1'b1;
            v = clamp64(v, -524288, 524287);
        end
        return v;
    endfunction

    // predicted undistorted pixel for one distorted pair
    function automatic pixel_out_t undistort_pixel(logic [15:0] pu, logic [15:0] pv);
        longint x0, y0, xc, yc, xx, yy, xy, r2, r4, r6, cd, a1, a2, a3, dx, dy;
        longint nx, ny;
        bit clip;
        pixel_out_t o;
        x0 = norm_coord(pu, lens_cx, lens_fx);
        y0 = norm_coord(pv, lens_cy, lens_fy);
        xc = x0;
        yc = y0;
        clip = 1'b0;
        for (int i = 0; i < ROUNDS; i++)
        begin
            xx = fx_mul(xc, xc);
            yy = fx_mul(yc, yc);
            xy = fx_mul(xc, yc);
            r2 = wclamp(xx + yy);
            r4 = fx_mul(r2, r2);
            r6 = fx_mul(r4, r2);
            cd = wclamp(fx_mul(lens_k1, r2) + fx_mul(lens_k2, r4) + fx_mul(0, r6));
            a1 = wclamp(2 * xy);
            a2 = wclamp(r2 + 2 * xx);
            a3 = wclamp(r2 + 2 * yy);
            dx = wclamp(fx_mul(lens_p1, a1) + fx_mul(lens_p2, a2));
            dy = wclamp(fx_mul(lens_p1, a3) + fx_mul(lens_p2, a1));
            nx = wclamp(x0 - fx_mul(xc, cd) - dx);
            ny = wclamp(y0 - fx_mul(yc, cd) - dy);
            xc = clamp64(nx, C_LO, C_HI);
            yc = clamp64(ny, C_LO, C_HI);
        end
        o.u = 20'(map_pixel(xc, lens_cx, lens_fx, clip));
        o.v = 20'(map_pixel(yc, lens_cy, lens_fy, clip));
        o.clip = clip;
        return o;
    endfunction

    // write one lens register, block must be idle
    task automatic write_lens_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_FOCAL_X:  lens_fx = val[15:0];
            REG_FOCAL_Y:  lens_fy = val[15:0];
            REG_CENTER_X: lens_cx = val[15:0];
            REG_CENTER_Y: lens_cy = val[15:0];
            REG_K1:       lens_k1 = longint'($signed(val));
            REG_K2:       lens_k2 = longint'($signed(val));
            REG_P1:       lens_p1 = longint'($signed(val));
            default:      lens_p2 = longint'($signed(val));
        endcase
    endtask

    task automatic set_lens(logic [15:0] fx, logic [15:0] fy, logic [15:0] cx,
                            logic [15:0] cy, logic [31:0] k1, logic [31:0] k2,
                            logic [31:0] p1, logic [31:0] p2);
        write_lens_reg(REG_FOCAL_X, {16'h0, fx});
        write_lens_reg(REG_FOCAL_Y, {16'h0, fy});
        write_lens_reg(REG_CENTER_X, {16'h0, cx});
        write_lens_reg(REG_CENTER_Y, {16'h0, cy});
        write_lens_reg(REG_K1, k1);
        write_lens_reg(REG_K2, k2);
        write_lens_reg(REG_P1, p1);
        write_lens_reg(REG_P2, p2);
        cfg_we <= 1'b0;
    endtask

    // send one point beat, with optional random gap before it
    task automatic send_point(logic [15:0] pu, logic [15:0] pv);
        if (!tail_quiet && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        start  <= 1'b1;
        dist_u <= pu;
        dist_v <= pv;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_pixels.push_back(undistort_pixel(pu, pv));
    endtask

    // wait until every expected pixel has come back
    task automatic drain_pipe();
        start <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat u=%0d v=%0d clip=%0d",
                             undist_u, undist_v, clipped);
            end
            else
            begin
                pixel_out_t e;
                e = pending_pixels.pop_front();
                if (e.u !== undist_u || e.v !== undist_v || e.clip !== clipped)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp u=%0d v=%0d clip=%0d got u=%0d v=%0d clip=%0d",
                                 e.u, e.v, e.clip, undist_u, undist_v, clipped);
                end
            end
        end
    end

    task automatic test_reset_lens();
        send_point(16'd5120, 16'd3840);
        send_point(16'd0, 16'd0);
        send_point(16'hFFFF, 16'hFFFF);
        send_point(16'h0000, 16'hFFFF);
        drain_pipe();
    endtask

    task automatic test_extremes();
        // zero focal length and saturating coefficients
        set_lens(16'd0, 16'd0, 16'd0, 16'hFFFF, 32'h7FFFFFFF, 32'h80000000,
                 32'h7FFFFFFF, 32'h80000000);
        send_point(16'd0, 16'd0);
        send_point(16'hFFFF, 16'hFFFF);
        send_point(16'h8000, 16'h0001);
        drain_pipe();
        set_lens(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 32'h80000000, 32'h7FFFFFFF,
                 32'h80000000, 32'h7FFFFFFF);
        send_point(16'd0, 16'hFFFF);
        send_point(16'hFFFF, 16'd0);
        send_point(16'h5555, 16'hAAAA);
        drain_pipe();
        // mild lens, points across the frame
        set_lens(16'd8000, 16'd8000, 16'd5120, 16'd3840, 32'shF8000000,
                 32'sh01000000, 32'sh00100000, 32'shFFF00000);
        for (int i = 0; i < 8; i++)
            send_point(16'(i * 9000), 16'(65535 - i * 9000));
        drain_pipe();
    endtask

    task automatic test_random_points(int n, bit wild);
        for (int i = 0; i < n; i++)
        begin
            if (i % 250 == 0)
            begin
                drain_pipe();
                if (wild)
                    set_lens(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                             $urandom, $urandom, $urandom, $urandom);
                else
                    set_lens(16'($urandom_range(1000, 20000)),
                             16'($urandom_range(1000, 20000)),
                             16'($urandom_range(2000, 10000)),
                             16'($urandom_range(2000, 10000)),
                             32'($signed($urandom_range(0, 32'h08000000)) - 32'sh04000000),
                             32'($signed($urandom_range(0, 32'h02000000)) - 32'sh01000000),
                             32'($signed($urandom_range(0, 32'h00400000)) - 32'sh00200000),
                             32'($signed($urandom_range(0, 32'h00400000)) - 32'sh00200000));
            end
            send_point(16'($urandom), 16'($urandom));
        end
        drain_pipe();
    endtask

    task automatic test_back_to_back();
        tail_quiet = 1'b1;
        for (int i = 0; i < 250; i++)
            send_point(16'($urandom), 16'($urandom));
        drain_pipe();
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        dist_u = '0;
        dist_v = '0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        mismatches = 0;
        tail_quiet = 1'b0;
        lens_fx = 8000; lens_fy = 8000; lens_cx = 5120; lens_cy = 3840;
        lens_k1 = 0; lens_k2 = 0; lens_p1 = 0; lens_p2 = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_lens();
        test_extremes();
        test_random_points(1000, 1'b0);
        test_random_points(500, 1'b1);
        test_back_to_back();
        repeat (LATENCY + 20) @(posedge clk);
        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule
